/* sv/spg_pkg.sv */
package spg_pkg;

  // Block sizing
  localparam int CHANNELS  = 4;
  localparam int SEG_DEPTH = 64;

  localparam int CH_W       = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int AW         = $clog2(SEG_DEPTH);
  localparam int LEN_W      = $clog2(SEG_DEPTH + 1);
  localparam int MASK_W     = (CHANNELS > 4) ? CHANNELS : 4;

  // Fixed field widths
  localparam int FUNC_W       = 2;
  localparam int IN_CH_W      = 2;
  localparam int IN_ADDR_W    = 6;
  localparam int IN_ADDR_SPAN = 64;
  localparam int DUR_W        = 16;
  localparam int IN_LEN_W     = 7;
  localparam int OUT_MASK_W   = 4;
  localparam int WORD_W       = DUR_W + 1;
  localparam int LEVEL_BIT    = DUR_W;

  typedef enum logic [FUNC_W-1:0] {
    FN_TICK   = 2'd0,
    FN_WRITE  = 2'd1,
    FN_SELECT = 2'd2,
    FN_NOP    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CHECK,
    ST_LOAD,
    ST_SLOAD,
    ST_DONE
  } state_t;

  typedef enum logic [2:0] {
    BOP_NONE,
    BOP_SELECT,
    BOP_STEP,
    BOP_LOAD,
    BOP_SEL_LEVEL
  } bank_op_t;

  // Sequencer to channel bank
  typedef struct packed {
    bank_op_t              op;
    logic                  clr_edges;
    logic [CH_W-1:0]       ch;
    logic [AW-1:0]         start;
    logic [LEN_W-1:0]      len;
    logic [WORD_W-1:0]     word;
  } bank_ctl_t;

  // Channel bank to sequencer
  typedef struct packed {
    logic                  len_zero;
    logic                  hit;
    logic [AW-1:0]         addr_cur;
    logic [AW-1:0]         addr_next;
    logic [MASK_W-1:0]     levels;
    logic [MASK_W-1:0]     rise;
    logic [MASK_W-1:0]     fall;
  } bank_sts_t;

  // Reduction of a 6-bit address into the store, worked out at elaboration
  typedef logic [AW-1:0] start_tbl_t [IN_ADDR_SPAN];

  function automatic start_tbl_t build_start_mod();
    start_tbl_t t;
    for (int i = 0; i < IN_ADDR_SPAN; i++) begin
      t[i] = AW'(i % SEG_DEPTH);
    end
    return t;
  endfunction

  localparam start_tbl_t START_MOD_TBL = build_start_mod();

  // Add two store addresses with wrap; both operands are below SEG_DEPTH
  function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [AW-1:0] b);
    logic [AW:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    if (sum >= (AW+1)'(SEG_DEPTH)) begin
      sum = sum - (AW+1)'(SEG_DEPTH);
    end
    return sum[AW-1:0];
  endfunction

endpackage

/* sv/spg_ram.sv */
module spg_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* sv/spg_chan_bank.sv */
module spg_chan_bank (
  input  logic              clk,
  input  logic              rst_n,
  input  spg_pkg::bank_ctl_t ctl,
  output spg_pkg::bank_sts_t sts
);
  import spg_pkg::*;

  logic [AW-1:0]    start_r [CHANNELS];
  logic [AW-1:0]    start_nxt [CHANNELS];
  logic [LEN_W-1:0] len_r [CHANNELS];
  logic [LEN_W-1:0] len_nxt [CHANNELS];
  logic [AW-1:0]    pos_r [CHANNELS];
  logic [AW-1:0]    pos_nxt [CHANNELS];
  logic [DUR_W-1:0] ticks_r [CHANNELS];
  logic [DUR_W-1:0] ticks_nxt [CHANNELS];
  logic [CHANNELS-1:0] lvl_r, lvl_nxt;
  logic [CHANNELS-1:0] rise_r, rise_nxt;
  logic [CHANNELS-1:0] fall_r, fall_nxt;

  logic [LEN_W-1:0] pos_inc;
  logic [AW-1:0]    pos_adv;
  logic             hit;
  logic             new_lvl;

  // Shared unit: counter compare and position advance for the addressed channel
  always_comb begin
    hit     = ticks_r[ctl.ch] >= ctl.word[DUR_W-1:0];
    pos_inc = LEN_W'(pos_r[ctl.ch]) + LEN_W'(1);
    pos_adv = (pos_inc == len_r[ctl.ch]) ? '0 : pos_inc[AW-1:0];
    new_lvl = ctl.word[LEVEL_BIT];
  end

  // Update the addressed channel
  always_comb begin
    start_nxt = start_r;
    len_nxt   = len_r;
    pos_nxt   = pos_r;
    ticks_nxt = ticks_r;
    lvl_nxt   = lvl_r;
    rise_nxt  = rise_r;
    fall_nxt  = fall_r;
    if (ctl.clr_edges) begin
      rise_nxt = '0;
      fall_nxt = '0;
    end
    case (ctl.op)
      BOP_SELECT: begin
        start_nxt[ctl.ch] = ctl.start;
        len_nxt[ctl.ch]   = ctl.len;
        pos_nxt[ctl.ch]   = '0;
        ticks_nxt[ctl.ch] = '0;
        if (ctl.len == '0) begin
          lvl_nxt[ctl.ch] = 1'b0;
        end
      end
      BOP_STEP: begin
        if (hit) begin
          ticks_nxt[ctl.ch] = '0;
          pos_nxt[ctl.ch]   = pos_adv;
        end else begin
          ticks_nxt[ctl.ch] = ticks_r[ctl.ch] + DUR_W'(1);
        end
      end
      BOP_LOAD: begin
        if (!lvl_r[ctl.ch] && new_lvl) begin
          rise_nxt[ctl.ch] = 1'b1;
        end
        if (lvl_r[ctl.ch] && !new_lvl) begin
          fall_nxt[ctl.ch] = 1'b1;
        end
        lvl_nxt[ctl.ch]   = new_lvl;
        ticks_nxt[ctl.ch] = DUR_W'(1);
      end
      BOP_SEL_LEVEL: begin
        lvl_nxt[ctl.ch] = new_lvl;
      end
      default: begin
      end
    endcase
  end

  // Hold channel state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        start_r[i] <= '0;
        len_r[i]   <= '0;
        pos_r[i]   <= '0;
        ticks_r[i] <= '0;
      end
      lvl_r  <= '0;
      rise_r <= '0;
      fall_r <= '0;
    end else begin
      start_r <= start_nxt;
      len_r   <= len_nxt;
      pos_r   <= pos_nxt;
      ticks_r <= ticks_nxt;
      lvl_r   <= lvl_nxt;
      rise_r  <= rise_nxt;
      fall_r  <= fall_nxt;
    end
  end

  // Status back to the sequencer
  always_comb begin
    sts.len_zero  = (len_r[ctl.ch] == '0);
    sts.hit       = hit;
    sts.addr_cur  = wrap_add(start_r[ctl.ch], pos_r[ctl.ch]);
    sts.addr_next = wrap_add(start_r[ctl.ch], pos_adv);
    sts.levels    = MASK_W'(lvl_r);
    sts.rise      = MASK_W'(rise_r);
    sts.fall      = MASK_W'(fall_r);
  end

  a_edge_excl: assert property (@(posedge clk) disable iff (!rst_n)
    (rise_r & fall_r) == '0)
    else $error("channel reported rising and falling on one tick");

  a_step_live: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == BOP_STEP) |-> (len_r[ctl.ch] != '0))
    else $error("idle channel stepped");

  a_load_after_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.op == BOP_LOAD) |-> (ticks_r[ctl.ch] == '0))
    else $error("segment load without a completed segment");

endmodule

/* sv/segment_pattern_generator.sv */
// Multi-channel pattern generator. Raise start for one cycle while busy is low to
// hand over one item: a tick, a segment store write or a pattern select. Exactly
// one result follows, shown for a single cycle with out_valid high; the receiver
// cannot hold it off, so it must sample it in that cycle. A write goes straight to
// the result; a select with a nonzero pattern length first loads the start level
// from the store. A tick visits the four channels in order, skipping idle ones and
// stepping each with a nonzero pattern length (one store read for the current
// segment, one more when the segment ends). One single-port-read segment store and
// one compare/advance unit are walked over the channels in turn, which sets the
// tick length. busy is high from the transfer until the result cycle ends. No
// clearing pass after reset is needed.
module segment_pattern_generator (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [spg_pkg::FUNC_W-1:0]         in_func,
  input  logic [spg_pkg::IN_CH_W-1:0]        in_channel,
  input  logic [spg_pkg::IN_ADDR_W-1:0]      in_address,
  input  logic [spg_pkg::DUR_W-1:0]          in_duration,
  input  logic                               in_out_level,
  input  logic [spg_pkg::IN_LEN_W-1:0]       in_length,
  output logic                               out_valid,
  output logic [spg_pkg::OUT_MASK_W-1:0]     out_levels,
  output logic [spg_pkg::OUT_MASK_W-1:0]     out_rising,
  output logic [spg_pkg::OUT_MASK_W-1:0]     out_falling
);
  import spg_pkg::*;

  state_t          state_r, state_nxt;
  logic [CH_W-1:0] ch_r, ch_nxt;

  bank_ctl_t         ctl;
  bank_sts_t         sts;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic             accept;
  logic             sel_ok;
  logic [CH_W-1:0]  sel_ch;
  logic [LEN_W-1:0] len_sat;
  logic [AW-1:0]    in_start;
  logic             last_ch;

  // Decode the incoming item
  always_comb begin
    accept   = start && (state_r == ST_IDLE);
    sel_ok   = (32'(in_channel) < CHANNELS);
    sel_ch   = CH_W'(in_channel);
    len_sat  = (32'(in_length) > SEG_DEPTH) ? LEN_W'(SEG_DEPTH) : LEN_W'(in_length);
    in_start = START_MOD_TBL[in_address];
    last_ch  = (ch_r == CH_W'(CHANNELS - 1));
  end

  assign ram_waddr = in_start;
  assign ram_wdata = {in_out_level, in_duration};

  // Sequencer: next state, bank control and store addressing
  always_comb begin
    state_nxt     = state_r;
    ch_nxt        = ch_r;
    ram_we        = 1'b0;
    ram_raddr     = sts.addr_cur;
    ctl.op        = BOP_NONE;
    ctl.clr_edges = 1'b0;
    ctl.ch        = ch_r;
    ctl.start     = in_start;
    ctl.len       = len_sat;
    ctl.word      = ram_rdata;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          ctl.clr_edges = 1'b1;
          case (func_t'(in_func))
            FN_TICK: begin
              ch_nxt    = '0;
              ctl.ch    = '0;
              state_nxt = ST_SCAN;
            end
            FN_WRITE: begin
              ram_we    = 1'b1;
              state_nxt = ST_DONE;
            end
            FN_SELECT: begin
              state_nxt = ST_DONE;
              if (sel_ok) begin
                ctl.op    = BOP_SELECT;
                ctl.ch    = sel_ch;
                ch_nxt    = sel_ch;
                ram_raddr = in_start;
                if (len_sat != '0) begin
                  state_nxt = ST_SLOAD;
                end
              end
            end
            default: begin
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_SCAN: begin
        // Skip idle channels, else fetch the current segment
        if (sts.len_zero) begin
          ch_nxt    = last_ch ? ch_r : ch_r + CH_W'(1);
          state_nxt = last_ch ? ST_DONE : ST_SCAN;
        end else begin
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        ctl.op = BOP_STEP;
        if (sts.hit) begin
          ram_raddr = sts.addr_next;
          state_nxt = ST_LOAD;
        end else begin
          ch_nxt    = last_ch ? ch_r : ch_r + CH_W'(1);
          state_nxt = last_ch ? ST_DONE : ST_SCAN;
        end
      end
      ST_LOAD: begin
        ctl.op    = BOP_LOAD;
        ch_nxt    = last_ch ? ch_r : ch_r + CH_W'(1);
        state_nxt = last_ch ? ST_DONE : ST_SCAN;
      end
      ST_SLOAD: begin
        ctl.op    = BOP_SEL_LEVEL;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Hold sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ch_r    <= '0;
    end else begin
      state_r <= state_nxt;
      ch_r    <= ch_nxt;
    end
  end

  spg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (SEG_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  spg_chan_bank u_bank (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .sts   (sts)
  );

  // Present the result for its single cycle
  assign busy        = (state_r != ST_IDLE);
  assign out_valid   = (state_r == ST_DONE);
  assign out_levels  = sts.levels[OUT_MASK_W-1:0];
  assign out_rising  = sts.rise[OUT_MASK_W-1:0];
  assign out_falling = sts.fall[OUT_MASK_W-1:0];

  a_busy_after: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("transfer not followed by busy");

  a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for more than one cycle");

  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_func == FN_WRITE)) |=> out_valid)
    else $error("store write did not report at once");

  a_quiet_edges: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(state_r) == ST_SLOAD) |-> (sts.rise == '0 && sts.fall == '0))
    else $error("select reported an edge");

endmodule
